// ===== hdl/nrcp_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and codes of the nested region cycle profiler
package nrcp_pkg;

	localparam int SLOT_W      = 12;
	localparam int SLOT_COUNT  = 1 << SLOT_W;
	localparam int STACK_DEPTH = 64;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int TICK_W      = 64;

	typedef enum logic [1:0] {
		CMD_ENTER = 2'd0,
		CMD_EXIT  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_code_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_POP,
		ST_SUB,
		ST_UPD
	} state_t;

	typedef enum logic [1:0] {
		K_READ,
		K_ENTER,
		K_FULL,
		K_EMPTY
	} kind_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] parent;
		logic [TICK_W-1:0] old_incl;
		logic [TICK_W-1:0] start;
	} frame_t;

	typedef struct packed {
		logic              accept;
		logic              rd_parent;
		logic              clr;
		logic [SLOT_W-1:0] clr_addr;
		logic              pop;
		logic              sub;
		logic              upd;
		logic              push;
		logic              out_load;
		status_t           out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic level_zero;
		logic level_full;
	} dp_stat_t;

endpackage

// ===== hdl/nrcp_req_if.sv =====
`timescale 1ns / 1ps
// request channel interface carrying one profiler event per transaction
interface nrcp_req_if
	import nrcp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [SLOT_W-1:0] slot_index;
	logic [TICK_W-1:0] timestamp;

	modport source (output valid, command, slot_index, timestamp, input ready);
	modport sink (input valid, command, slot_index, timestamp, output ready);
endinterface

// ===== hdl/nrcp_rsp_if.sv =====
`timescale 1ns / 1ps
// response channel interface carrying one slot record per transaction
interface nrcp_rsp_if
	import nrcp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] record_slot;
	logic [TICK_W-1:0] exclusive_ticks;
	logic [TICK_W-1:0] inclusive_ticks;
	logic [TICK_W-1:0] hits;
	logic [LVL_W-1:0]  nesting_depth;

	modport source (output valid, status, record_slot, exclusive_ticks, inclusive_ticks,
		hits, nesting_depth, input ready);
	modport sink (input valid, status, record_slot, exclusive_ticks, inclusive_ticks,
		hits, nesting_depth, output ready);
endinterface

// ===== hdl/nrcp_dp.sv =====
`timescale 1ns / 1ps
// profiler datapath: slot tables, frame stack, elapsed arithmetic and result register
module nrcp_dp
	import nrcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [SLOT_W-1:0] req_slot,
	input  logic [TICK_W-1:0] req_ts,
	output dp_stat_t          stat,
	output logic [1:0]        status_q,
	output logic [SLOT_W-1:0] slot_q,
	output logic [TICK_W-1:0] excl_q,
	output logic [TICK_W-1:0] incl_q,
	output logic [TICK_W-1:0] hits_q,
	output logic [LVL_W-1:0]  depth_q
);

	logic [TICK_W-1:0] excl_mem [SLOT_COUNT];
	logic [TICK_W-1:0] incl_mem [SLOT_COUNT];
	logic [TICK_W-1:0] hit_mem [SLOT_COUNT];
	frame_t            stk_mem [STACK_DEPTH];

	logic [SLOT_W-1:0] cur_parent_q;
	logic [LVL_W-1:0]  level_q;
	logic [SLOT_W-1:0] rec_q;
	logic [TICK_W-1:0] ts_q;
	logic [SLOT_W-1:0] s_q;
	logic [SLOT_W-1:0] p_q;
	logic [TICK_W-1:0] old_incl_q;
	logic [TICK_W-1:0] elapsed_q;
	logic [TICK_W-1:0] excl_rd_q;
	logic [TICK_W-1:0] incl_rd_q;
	logic [TICK_W-1:0] hit_rd_q;
	frame_t            stk_rd_q;

	logic [SLOT_W-1:0] rec_addr_d;
	logic [SLOT_W-1:0] tab_raddr;
	logic              tab_re;
	logic              excl_we;
	logic [SLOT_W-1:0] excl_waddr;
	logic [TICK_W-1:0] excl_wdata;
	logic              su_we;
	logic [SLOT_W-1:0] su_waddr;
	logic [TICK_W-1:0] incl_wdata;
	logic [TICK_W-1:0] hit_wdata;
	logic [TICK_W-1:0] excl_new;
	logic [TICK_W-1:0] incl_new;
	logic [TICK_W-1:0] hit_new;
	logic [LVL_W-1:0]  lvl_m1;
	frame_t            push_frame;

	assign rec_addr_d = cmd.rd_parent ? cur_parent_q : req_slot;
	assign tab_raddr  = cmd.accept ? rec_addr_d : (cmd.pop ? stk_rd_q.parent : s_q);
	assign tab_re     = cmd.accept | cmd.pop | cmd.sub;

	// recursive frame: the parent subtraction and slot addition cancel
	assign excl_new = (s_q == p_q) ? excl_rd_q : excl_rd_q + elapsed_q;
	assign incl_new = old_incl_q + elapsed_q;
	assign hit_new  = hit_rd_q + TICK_W'(1);

	assign excl_we    = cmd.clr | cmd.sub | cmd.upd;
	assign excl_waddr = cmd.clr ? cmd.clr_addr : (cmd.sub ? p_q : s_q);
	assign excl_wdata = cmd.clr ? '0 : (cmd.sub ? excl_rd_q - elapsed_q : excl_new);
	assign su_we      = cmd.clr | cmd.upd;
	assign su_waddr   = cmd.clr ? cmd.clr_addr : s_q;
	assign incl_wdata = cmd.clr ? '0 : incl_new;
	assign hit_wdata  = cmd.clr ? '0 : hit_new;

	assign lvl_m1     = level_q - LVL_W'(1);
	assign push_frame = '{slot: rec_q, parent: cur_parent_q, old_incl: incl_rd_q, start: ts_q};

	assign stat.level_zero = (level_q == '0);
	assign stat.level_full = (level_q == LVL_W'(STACK_DEPTH));

	always_ff @(posedge clk) begin
		if (excl_we) begin
			excl_mem[excl_waddr] <= excl_wdata;
		end
		if (tab_re) begin
			excl_rd_q <= excl_mem[tab_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (su_we) begin
			incl_mem[su_waddr] <= incl_wdata;
		end
		if (tab_re) begin
			incl_rd_q <= incl_mem[tab_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (su_we) begin
			hit_mem[su_waddr] <= hit_wdata;
		end
		if (tab_re) begin
			hit_rd_q <= hit_mem[tab_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_mem[level_q[STK_AW-1:0]] <= push_frame;
		end
		if (cmd.accept) begin
			stk_rd_q <= stk_mem[lvl_m1[STK_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_parent_q <= '0;
			level_q      <= '0;
		end else if (cmd.pop) begin
			cur_parent_q <= stk_rd_q.parent;
			level_q      <= lvl_m1;
		end else if (cmd.push) begin
			cur_parent_q <= rec_q;
			level_q      <= level_q + LVL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rec_q <= rec_addr_d;
			ts_q  <= req_ts;
		end
		if (cmd.pop) begin
			s_q        <= stk_rd_q.slot;
			p_q        <= stk_rd_q.parent;
			old_incl_q <= stk_rd_q.old_incl;
			elapsed_q  <= ts_q - stk_rd_q.start;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			if (cmd.upd) begin
				slot_q  <= s_q;
				excl_q  <= excl_new;
				incl_q  <= incl_new;
				hits_q  <= hit_new;
				depth_q <= level_q;
			end else begin
				slot_q  <= rec_q;
				excl_q  <= excl_rd_q;
				incl_q  <= incl_rd_q;
				hits_q  <= hit_rd_q;
				depth_q <= cmd.push ? level_q + LVL_W'(1) : level_q;
			end
		end
	end

endmodule

// ===== hdl/nrcp_ctrl.sv =====
`timescale 1ns / 1ps
// profiler controller: clearing pass, command decode and transaction sequencing
module nrcp_ctrl
	import nrcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_command,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	state_t            state_q, state_d;
	kind_t             kind_q, kind_d;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic              rsp_valid_q;
	logic              out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			kind_q      <= K_READ;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr      = 1'b1;
				cmd.clr_addr = clr_cnt_q;
				if (clr_cnt_q == SLOT_W'(SLOT_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (cmd_code_t'(req_command))
						CMD_ENTER: begin
							kind_d  = stat.level_full ? K_FULL : K_ENTER;
							state_d = ST_LOOK;
						end
						CMD_EXIT: begin
							if (stat.level_zero) begin
								kind_d        = K_EMPTY;
								cmd.rd_parent = 1'b1;
								state_d       = ST_LOOK;
							end else begin
								state_d = ST_POP;
							end
						end
						default: begin
							kind_d  = K_READ;
							state_d = ST_LOOK;
						end
					endcase
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					case (kind_q)
						K_ENTER: begin
							cmd.push       = 1'b1;
							cmd.out_status = STS_OK;
						end
						K_FULL:  cmd.out_status = STS_FULL;
						K_EMPTY: cmd.out_status = STS_EMPTY;
						default: cmd.out_status = STS_OK;
					endcase
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					cmd.upd        = 1'b1;
					cmd.out_load   = 1'b1;
					cmd.out_status = STS_OK;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/nested_region_cycle_profiler.sv =====
`timescale 1ns / 1ps
// enter, read, full-stack enter and empty-stack exit: result loaded in the look state after acceptance
// exit: result loaded after the frame pop, parent update and slot update states, once the result register is free
// a new request is accepted only once the previous transaction is through, as set by the registered table reads
// and the read-modify-write of parent then slot in the exclusive table
// after reset a clearing pass zeroes the slot tables, one slot at a time, with req.ready low
// the result register lets the next transaction be accepted while a result waits
module nested_region_cycle_profiler
	import nrcp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	nrcp_req_if.sink   req,
	nrcp_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	nrcp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	nrcp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_slot (req.slot_index),
		.req_ts   (req.timestamp),
		.stat     (stat),
		.status_q (rsp.status),
		.slot_q   (rsp.record_slot),
		.excl_q   (rsp.exclusive_ticks),
		.incl_q   (rsp.inclusive_ticks),
		.hits_q   (rsp.hits),
		.depth_q  (rsp.nesting_depth)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a transaction is in progress");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.nesting_depth <= LVL_W'(STACK_DEPTH))
		else $error("nesting depth beyond stack size");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STS_FULL |-> rsp.nesting_depth == LVL_W'(STACK_DEPTH))
		else $error("full status without a full stack");

	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STS_EMPTY |-> rsp.nesting_depth == '0)
		else $error("empty status without an empty stack");

endmodule

// ===== bench/tb_nested_region_cycle_profiler.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the nested region cycle profiler: directed, overflow and random nesting
module tb_nested_region_cycle_profiler;
	import nrcp_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [TICK_W-1:0] excl;
		logic [TICK_W-1:0] incl;
		logic [TICK_W-1:0] hits;
		logic [LVL_W-1:0]  depth;
	} slot_record_t;

	logic clk;
	logic arst_n;

	nrcp_req_if req_ch ();
	nrcp_rsp_if rsp_ch ();

	nested_region_cycle_profiler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// profiler image kept by the testbench
	logic [TICK_W-1:0] excl_tbl [SLOT_COUNT];
	logic [TICK_W-1:0] incl_tbl [SLOT_COUNT];
	logic [TICK_W-1:0] hit_tbl [SLOT_COUNT];
	logic [SLOT_W-1:0] frm_slot [STACK_DEPTH];
	logic [SLOT_W-1:0] frm_parent [STACK_DEPTH];
	logic [TICK_W-1:0] frm_old_incl [STACK_DEPTH];
	logic [TICK_W-1:0] frm_start [STACK_DEPTH];
	logic [SLOT_W-1:0] open_parent;
	int                open_depth;

	slot_record_t      pending_records [$];
	logic [TICK_W-1:0] stamp_now;
	int                send_gap_pct;
	int                rsp_stall_pct;
	int                mismatch_cnt;
	int                sent_cnt;
	int                checked_cnt;
	int                deepest;
	int                drop_full_cnt;
	int                drop_empty_cnt;
	int                cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
				pending_records.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic slot_record_t profile_event(logic [1:0] cmd, logic [SLOT_W-1:0] slot,
		logic [TICK_W-1:0] ts);
		slot_record_t      r;
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] p;
		logic [TICK_W-1:0] elapsed;
		int                lv;
		r.status = STS_OK;
		s = slot;
		if (cmd == CMD_ENTER) begin
			if (open_depth >= STACK_DEPTH) begin
				r.status = STS_FULL;
				drop_full_cnt++;
			end else begin
				lv = open_depth;
				frm_slot[lv] = slot;
				frm_parent[lv] = open_parent;
				frm_old_incl[lv] = incl_tbl[slot];
				frm_start[lv] = ts;
				open_depth = lv + 1;
				open_parent = slot;
				if (open_depth > deepest)
					deepest = open_depth;
			end
		end else if (cmd == CMD_EXIT) begin
			if (open_depth == 0) begin
				r.status = STS_EMPTY;
				s = open_parent;
				drop_empty_cnt++;
			end else begin
				lv = open_depth - 1;
				s = frm_slot[lv];
				p = frm_parent[lv];
				elapsed = ts - frm_start[lv];
				open_depth = lv;
				open_parent = p;
				// parent first, so a recursive frame cancels out
				excl_tbl[p] = excl_tbl[p] - elapsed;
				excl_tbl[s] = excl_tbl[s] + elapsed;
				incl_tbl[s] = frm_old_incl[lv] + elapsed;
				hit_tbl[s] = hit_tbl[s] + TICK_W'(1);
			end
		end
		r.slot = s;
		r.excl = excl_tbl[s];
		r.incl = incl_tbl[s];
		r.hits = hit_tbl[s];
		r.depth = open_depth[LVL_W-1:0];
		return r;
	endfunction

	function automatic logic [TICK_W-1:0] next_stamp();
		if ($urandom_range(19) == 0)
			stamp_now = {$urandom, $urandom};
		else
			stamp_now = stamp_now + TICK_W'($urandom_range(1, 400));
		return stamp_now;
	endfunction

	// mostly a handful of hot slots so that regions recurse and repeat
	function automatic logic [SLOT_W-1:0] pick_slot();
		if ($urandom_range(99) < 75)
			return SLOT_W'($urandom_range(5));
		return SLOT_W'($urandom_range(SLOT_COUNT - 1));
	endfunction

	// entered and left at a falling edge
	task automatic send_event(logic [1:0] cmd, logic [SLOT_W-1:0] slot, logic [TICK_W-1:0] ts);
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.slot_index <= slot;
		req_ch.timestamp <= ts;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_records.push_back(profile_event(cmd, slot, ts));
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic flag_field(string name, logic [TICK_W-1:0] exp_val, logic [TICK_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t %s expected %0h got %0h", $time, name, exp_val, act_val);
			mismatch_cnt++;
		end
	endtask

	// result checker
	initial begin
		slot_record_t e;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				checked_cnt++;
				if (pending_records.size() == 0) begin
					$display("%0t unexpected transaction: expected none got slot %0h", $time,
						rsp_ch.record_slot);
					mismatch_cnt++;
				end else begin
					e = pending_records.pop_front();
					flag_field("status", e.status, rsp_ch.status);
					flag_field("record_slot", e.slot, rsp_ch.record_slot);
					flag_field("exclusive_ticks", e.excl, rsp_ch.exclusive_ticks);
					flag_field("inclusive_ticks", e.incl, rsp_ch.inclusive_ticks);
					flag_field("hits", e.hits, rsp_ch.hits);
					flag_field("nesting_depth", e.depth, rsp_ch.nesting_depth);
				end
			end
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	task automatic test_directed_cases();
		send_event(CMD_READ, 12'h000, 64'd0);
		send_event(CMD_READ, 12'hFFF, '1);
		send_event(CMD_SPARE, 12'hABC, 64'h5555_5555_5555_5555);
		// exit with nothing open reports the current parent
		send_event(CMD_EXIT, 12'h123, 64'd7);
		send_event(CMD_ENTER, 12'hFFF, 64'd0);
		// recursive region
		send_event(CMD_ENTER, 12'hFFF, 64'd5);
		send_event(CMD_EXIT, 12'h000, '1);
		send_event(CMD_EXIT, 12'hFFF, 64'd1);
		send_event(CMD_READ, 12'hFFF, 64'd2);
		// parent starting before the wrap of the timestamp, child after it
		send_event(CMD_ENTER, 12'h000, '1);
		send_event(CMD_ENTER, 12'h001, 64'd10);
		send_event(CMD_READ, 12'h001, 64'hAAAA_AAAA_AAAA_AAAA);
		send_event(CMD_EXIT, 12'h555, 64'd20);
		send_event(CMD_EXIT, 12'hAAA, 64'd30);
		send_event(CMD_READ, 12'h000, 64'd31);
		send_event(CMD_READ, 12'h001, 64'd32);
		send_event(CMD_EXIT, 12'h000, 64'd33);
		send_event(CMD_SPARE, 12'h001, 64'd34);
		send_event(CMD_ENTER, 12'h001, 64'd40);
		send_event(CMD_EXIT, 12'h001, 64'd39);
	endtask

	task automatic test_stack_overflow();
		int k;
		for (k = 0; k < STACK_DEPTH; k++)
			send_event(CMD_ENTER, pick_slot(), next_stamp());
		send_event(CMD_ENTER, 12'hFFF, next_stamp());
		send_event(CMD_ENTER, pick_slot(), next_stamp());
		send_event(CMD_READ, pick_slot(), next_stamp());
		for (k = 0; k < STACK_DEPTH; k++)
			send_event(CMD_EXIT, pick_slot(), next_stamp());
		send_event(CMD_EXIT, pick_slot(), next_stamp());
		send_event(CMD_EXIT, pick_slot(), next_stamp());
	endtask

	task automatic test_random_nesting(int count);
		int k;
		int roll;
		int enter_cut;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			enter_cut = (open_depth < 12) ? 52 : 38;
			if (roll < 5)
				send_event(2'($urandom_range(3)), pick_slot(), next_stamp());
			else if (roll < enter_cut)
				send_event(CMD_ENTER, pick_slot(), next_stamp());
			else if (roll < 88)
				send_event(CMD_EXIT, pick_slot(), next_stamp());
			else
				send_event(CMD_READ, pick_slot(), next_stamp());
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_READ;
		req_ch.slot_index = '0;
		req_ch.timestamp = '0;
		mismatch_cnt = 0;
		sent_cnt = 0;
		checked_cnt = 0;
		deepest = 0;
		drop_full_cnt = 0;
		drop_empty_cnt = 0;
		cycle_cnt = 0;
		open_depth = 0;
		open_parent = '0;
		stamp_now = '0;
		for (i = 0; i < SLOT_COUNT; i++) begin
			excl_tbl[i] = '0;
			incl_tbl[i] = '0;
			hit_tbl[i] = '0;
		end
		send_gap_pct = 7;
		rsp_stall_pct = 51;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_stack_overflow();
		test_random_nesting(110);

		send_gap_pct = 51;
		rsp_stall_pct = 7;
		test_random_nesting(110);

		send_gap_pct = 0;
		rsp_stall_pct = 0;
		test_random_nesting(110);

		req_ch.valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d transactions, %0d results checked, deepest nesting %0d", sent_cnt,
			checked_cnt, deepest);
		$display("dropped enters on a full stack %0d, exits on an empty stack %0d", drop_full_cnt,
			drop_empty_cnt);
		if (mismatch_cnt == 0 && pending_records.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
